### sv/flp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package flp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned SumW    = 16;
  localparam int unsigned PktCntW = 9;
  localparam int unsigned WppW    = 8;
  localparam int unsigned PaddrW  = 3;
  localparam int unsigned PdataW  = 32;

  localparam logic [ByteW-1:0]  HeaderHi = 8'h7F;
  localparam logic [ByteW-1:0]  HeaderLo = 8'hFF;
  localparam logic [WppW-1:0]   WppReset = 8'd9;

  localparam logic [PaddrW-1:0] AddrWpp  = 3'd0;

  typedef struct packed {
    logic             hdr;
    logic             csum;
    logic [ByteW-1:0] data;
    logic [SumW-1:0]  sum;
  } cmd_t;

  localparam int unsigned CmdW = $bits(cmd_t);

  typedef enum logic [5:0] {
    ST_FIRST  = 6'b000001,
    ST_HDR_HI = 6'b000010,
    ST_HDR_LO = 6'b000100,
    ST_DATA   = 6'b001000,
    ST_SUM_HI = 6'b010000,
    ST_SUM_LO = 6'b100000
  } phase_e;

endpackage

`default_nettype wire

### sv/flp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module flp_front #(
  parameter int unsigned BLOCK_BYTES = 256
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          accept_i,
  input  wire  [flp_pkg::ByteW-1:0]    data_i,
  input  wire  [flp_pkg::WppW-1:0]     wpp_i,
  output flp_pkg::cmd_t                cmd_o
);

  localparam int unsigned BlkW = (BLOCK_BYTES > 2) ? $clog2(BLOCK_BYTES) : 1;
  localparam logic [BlkW-1:0] BlkLast = BlkW'(BLOCK_BYTES - 1);

  logic [flp_pkg::PktCntW-1:0] pkt_cnt_q, pkt_cnt_d;
  logic [flp_pkg::SumW-1:0]    sum_q, sum_d;
  logic [BlkW-1:0]             blk_cnt_q, blk_cnt_d;

  logic                        raw;
  logic [flp_pkg::PktCntW-1:0] limit;
  logic [flp_pkg::PktCntW-1:0] pkt_cnt_inc;
  logic [flp_pkg::SumW-1:0]    sum_inc;
  logic                        pkt_done;
  logic                        blk_end;

  always_comb begin
    raw         = (wpp_i <= flp_pkg::WppW'(1));
    limit       = {wpp_i, 1'b0};
    pkt_cnt_inc = pkt_cnt_q + flp_pkg::PktCntW'(1);
    sum_inc     = sum_q + flp_pkg::SumW'(data_i);
    pkt_done    = !raw && (pkt_cnt_inc >= limit);
    blk_end     = (blk_cnt_q == BlkLast);

    cmd_o.hdr  = !raw && (pkt_cnt_q == '0);
    cmd_o.csum = pkt_done;
    cmd_o.data = data_i;
    cmd_o.sum  = sum_inc;

    pkt_cnt_d = pkt_cnt_q;
    sum_d     = sum_q;
    if (!raw) begin
      pkt_cnt_d = pkt_done ? '0 : pkt_cnt_inc;
      sum_d     = pkt_done ? '0 : sum_inc;
    end
    blk_cnt_d = blk_cnt_q + BlkW'(1);
    if (blk_end) begin
      blk_cnt_d = '0;
      pkt_cnt_d = '0;
      sum_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_cnt_q <= '0;
      sum_q     <= '0;
      blk_cnt_q <= '0;
    end else if (accept_i) begin
      pkt_cnt_q <= pkt_cnt_d;
      sum_q     <= sum_d;
      blk_cnt_q <= blk_cnt_d;
    end
  end

endmodule

`default_nettype wire

### sv/flp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module flp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  flp_pkg::cmd_t  push_cmd_i,
  output logic           full_o,
  input  wire            pop_i,
  output logic           valid_o,
  output flp_pkg::cmd_t  head_o
);

  localparam int unsigned PtrW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);

  flp_pkg::cmd_t   mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  always_comb begin
    full_o  = (cnt_q == CntW'(DEPTH));
    valid_o = (cnt_q != '0);
    head_o  = mem_q[rd_ptr_q];
    do_push = push_i && !full_o;
    do_pop  = pop_i && valid_o;

    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

### sv/flp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module flp_back (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        cmd_valid_i,
  input  flp_pkg::cmd_t              cmd_i,
  output logic                       cmd_pop_o,
  output logic                       m_tvalid_o,
  input  wire                        m_tready_i,
  output logic [flp_pkg::ByteW-1:0]  m_tdata_o,
  output logic                       m_tlast_o
);

  flp_pkg::phase_e             state_q, state_d;
  flp_pkg::phase_e             phase;
  logic                        valid_q;
  logic [flp_pkg::ByteW-1:0]   byte_q, byte_d;
  logic                        last_q, last_d;
  logic                        advance;

  always_comb begin
    advance = cmd_valid_i && (!valid_q || m_tready_i);

    if (state_q == flp_pkg::ST_FIRST) begin
      phase = cmd_i.hdr ? flp_pkg::ST_HDR_HI : flp_pkg::ST_DATA;
    end else begin
      phase = state_q;
    end

    byte_d  = cmd_i.data;
    last_d  = 1'b0;
    state_d = state_q;
    case (phase)
      flp_pkg::ST_HDR_HI: begin
        byte_d  = flp_pkg::HeaderHi;
        state_d = flp_pkg::ST_HDR_LO;
      end
      flp_pkg::ST_HDR_LO: begin
        byte_d  = flp_pkg::HeaderLo;
        state_d = flp_pkg::ST_DATA;
      end
      flp_pkg::ST_DATA: begin
        byte_d  = cmd_i.data;
        last_d  = !cmd_i.csum;
        state_d = cmd_i.csum ? flp_pkg::ST_SUM_HI : flp_pkg::ST_FIRST;
      end
      flp_pkg::ST_SUM_HI: begin
        byte_d  = cmd_i.sum[flp_pkg::SumW-1:flp_pkg::ByteW];
        state_d = flp_pkg::ST_SUM_LO;
      end
      flp_pkg::ST_SUM_LO: begin
        byte_d  = cmd_i.sum[flp_pkg::ByteW-1:0];
        last_d  = 1'b1;
        state_d = flp_pkg::ST_FIRST;
      end
      default: begin
        state_d = flp_pkg::ST_FIRST;
      end
    endcase

    cmd_pop_o  = advance && last_d;
    m_tvalid_o = valid_q;
    m_tdata_o  = byte_q;
    m_tlast_o  = last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= flp_pkg::ST_FIRST;
      valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
        valid_q <= 1'b1;
      end else if (m_tready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      byte_q <= byte_d;
      last_q <= last_d;
    end
  end

endmodule

`default_nettype wire

### sv/flash_log_packetizer.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  transaction
// s_axis    in         one logged data byte
// m_axis    out        one link byte (header, data or checksum), tlast on the last per input
// apb       in         register write or read, words_per_packet at address 0
//
// an input byte is taken every cycle while the command queue has room
// the output gives one byte per cycle with the sink ready: 1 per raw or mid-packet byte,
// 3 at packet start or end; a checksum needs 4+ data bytes, so no input causes more than 3
// the output byte register is the limit; the front runs ahead by QUEUE_DEPTH commands
// reset clears counters, sum, queue and output, and sets words_per_packet to 9

module flash_log_packetizer #(
  parameter int unsigned BLOCK_BYTES = 256,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  wire  [7:0]                   s_axis_tdata_i,  // data_byte
  output logic                         m_axis_tvalid_o,
  input  wire                          m_axis_tready_i,
  output logic [7:0]                   m_axis_tdata_o,  // out_byte
  output logic                         m_axis_tlast_o,  // last_of_run
  input  wire                          psel_i,
  input  wire                          penable_i,
  input  wire                          pwrite_i,
  input  wire  [flp_pkg::PaddrW-1:0]   paddr_i,
  input  wire  [flp_pkg::PdataW-1:0]   pwdata_i,
  output logic [flp_pkg::PdataW-1:0]   prdata_o,
  output logic                         pready_o
);

  logic [flp_pkg::WppW-1:0] wpp_q;
  logic                     in_accept;
  logic                     q_full;
  logic                     q_valid;
  logic                     q_pop;
  flp_pkg::cmd_t            front_cmd;
  flp_pkg::cmd_t            head_cmd;

  assign pready_o        = 1'b1;
  assign s_axis_tready_o = !q_full;
  assign in_accept       = s_axis_tvalid_i && !q_full;

  always_comb begin
    prdata_o = '0;
    if (paddr_i == flp_pkg::AddrWpp) begin
      prdata_o = flp_pkg::PdataW'(wpp_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpp_q <= flp_pkg::WppReset;
    end else if (psel_i && penable_i && pwrite_i && (paddr_i == flp_pkg::AddrWpp)) begin
      wpp_q <= pwdata_i[flp_pkg::WppW-1:0];
    end
  end

  flp_front #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(in_accept),
    .data_i  (s_axis_tdata_i),
    .wpp_i   (wpp_q),
    .cmd_o   (front_cmd)
  );

  flp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (in_accept),
    .push_cmd_i(front_cmd),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .valid_o   (q_valid),
    .head_o    (head_cmd)
  );

  flp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(q_valid),
    .cmd_i      (head_cmd),
    .cmd_pop_o  (q_pop),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire
